/* hw/rtl/tksp_pkg.sv */
// ----------------------------------------------------------------------------
// tksp_pkg: shared types and constants of the three-key speed panel
// Timing windows in milliseconds, counter widths, configuration register
// indexes and mode command codes.
// ----------------------------------------------------------------------------
package tksp_pkg;

  localparam int unsigned HELD_W  = 12;
  localparam int unsigned TICK_W  = 7;
  localparam int unsigned SPEED_W = 16;
  localparam int unsigned ACT_W   = 10;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [HELD_W-1:0] HELD_MAX         = 12'd4095;
  localparam logic [HELD_W-1:0] CLICK_LO_MS      = 12'd50;
  localparam logic [HELD_W-1:0] CLICK_HI_MS      = 12'd1500;
  localparam logic [HELD_W-1:0] REPEAT_LO_MS     = 12'd1900;
  localparam logic [HELD_W-1:0] REPEAT_HI_MS     = 12'd2100;
  localparam logic [HELD_W-1:0] REPEAT_RELOAD_MS = 12'd1400;
  localparam logic [HELD_W-1:0] LONG_LO_MS       = 12'd1500;
  localparam logic [HELD_W-1:0] LONG_HI_MS       = 12'd3000;
  localparam logic [ACT_W-1:0]  ACTIVITY_MS      = 10'd1000;

  localparam logic [SPEED_W:0]   SPEED_STEP      = 17'd100;
  localparam logic [SPEED_W-1:0] SPEED_MIN_RST   = 16'd100;
  localparam logic [SPEED_W-1:0] SPEED_MAX_RST   = 16'd3000;
  localparam logic [TICK_W-1:0]  TICK_MS_RST     = 7'd10;

  localparam logic [CFG_IDX_W-1:0] CFG_TICK_MS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_MIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_MAX = 2'd2;

  localparam logic [1:0] MODE_NONE  = 2'd0;
  localparam logic [1:0] MODE_RAMP  = 2'd1;
  localparam logic [1:0] MODE_DECEL = 2'd2;

  typedef logic [HELD_W-1:0] held_t;

  typedef struct packed {
    logic       click;
    logic       flash;
    logic [1:0] mode;
    logic       running;
  } start_evt_t;

  function automatic held_t held_add(held_t t, logic [TICK_W-1:0] tick);
    logic [HELD_W:0] s;
    s = {1'b0, t} + {{(HELD_W + 1 - TICK_W){1'b0}}, tick};
    return (s > {1'b0, HELD_MAX}) ? HELD_MAX : s[HELD_W-1:0];
  endfunction

endpackage

/* hw/rtl/tksp_speed_key.sv */
// ----------------------------------------------------------------------------
// tksp_speed_key: hold timer of one speed key
// Counts held time, detects a click on release and an auto-repeat while
// held, and raises a step request for either.
// ----------------------------------------------------------------------------
module tksp_speed_key (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  logic                        pressed,
  input  logic [tksp_pkg::TICK_W-1:0] tick_ms,
  output logic                        step
);
  import tksp_pkg::*;

  held_t held_r, held_nxt;
  logic  mark_r, mark_nxt;
  held_t t1;
  logic  m1;
  logic  click;
  logic  rep;

  always_comb begin
    t1       = pressed ? held_add(held_r, tick_ms) : held_r;
    m1       = pressed | mark_r;
    click    = 1'b0;
    held_nxt = t1;
    mark_nxt = m1;
    if (m1 && !pressed) begin
      click    = (t1 > CLICK_LO_MS) && (t1 < CLICK_HI_MS);
      held_nxt = '0;
      mark_nxt = 1'b0;
    end
    rep = m1 && (held_nxt > REPEAT_LO_MS) && (held_nxt < REPEAT_HI_MS);
    if (rep) begin
      held_nxt = REPEAT_RELOAD_MS;
      mark_nxt = 1'b0;
    end
    step = click | rep;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
      mark_r <= 1'b0;
    end else if (adv) begin
      held_r <= held_nxt;
      mark_r <= mark_nxt;
    end
  end

endmodule

/* hw/rtl/tksp_start_key.sv */
// ----------------------------------------------------------------------------
// tksp_start_key: start key handling and run status
// A click toggles the run status and issues a mode command; a long hold
// requests a flash once per press.
// ----------------------------------------------------------------------------
module tksp_start_key (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  logic                        pressed,
  input  logic [tksp_pkg::TICK_W-1:0] tick_ms,
  output tksp_pkg::start_evt_t        evt
);
  import tksp_pkg::*;

  held_t held_r, held_nxt;
  logic  mark_r, mark_nxt;
  logic  done_r, done_nxt;
  logic  run_r, run_nxt;
  logic  counting;
  held_t t1;
  logic  m1;
  logic  click;
  logic  flash;

  always_comb begin
    counting = pressed && !done_r;
    t1       = counting ? held_add(held_r, tick_ms) : held_r;
    m1       = counting | mark_r;
    click    = 1'b0;
    held_nxt = t1;
    mark_nxt = m1;
    done_nxt = done_r;
    if (m1 && !pressed) begin
      click    = (t1 > CLICK_LO_MS) && (t1 < CLICK_HI_MS);
      held_nxt = '0;
      mark_nxt = 1'b0;
      done_nxt = 1'b0;
    end
    flash = m1 && !done_nxt && (held_nxt > LONG_LO_MS) && (held_nxt < LONG_HI_MS);
    if (flash) begin
      done_nxt = 1'b1;
    end
    run_nxt = click ? !run_r : run_r;

    evt.click   = click;
    evt.flash   = flash;
    evt.running = run_nxt;
    evt.mode    = MODE_NONE;
    if (click) begin
      evt.mode = run_r ? MODE_DECEL : MODE_RAMP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
      mark_r <= 1'b0;
      done_r <= 1'b0;
      run_r  <= 1'b0;
    end else if (adv) begin
      held_r <= held_nxt;
      mark_r <= mark_nxt;
      done_r <= done_nxt;
      run_r  <= run_nxt;
    end
  end

endmodule

/* hw/rtl/tksp_setpoint.sv */
// ----------------------------------------------------------------------------
// tksp_setpoint: speed setpoint register
// Applies a decrement step and then an increment step, each clamped to the
// configured limits.
// ----------------------------------------------------------------------------
module tksp_setpoint (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  logic                         dec_step,
  input  logic                         inc_step,
  input  logic [tksp_pkg::SPEED_W-1:0] lo_limit,
  input  logic [tksp_pkg::SPEED_W-1:0] hi_limit,
  output logic [tksp_pkg::SPEED_W-1:0] speed_nxt
);
  import tksp_pkg::*;

  logic [SPEED_W-1:0] speed_r;
  logic [SPEED_W-1:0] after_dec;
  logic [SPEED_W:0]   floor_sum;
  logic [SPEED_W:0]   up_sum;

  always_comb begin
    floor_sum = {1'b0, lo_limit} + SPEED_STEP;
    after_dec = speed_r;
    if (dec_step) begin
      if ({1'b0, speed_r} < floor_sum) begin
        after_dec = lo_limit;
      end else begin
        after_dec = speed_r - SPEED_STEP[SPEED_W-1:0];
      end
    end
    up_sum    = {1'b0, after_dec} + SPEED_STEP;
    speed_nxt = after_dec;
    if (inc_step) begin
      if (up_sum > {1'b0, hi_limit}) begin
        speed_nxt = hi_limit;
      end else begin
        speed_nxt = up_sum[SPEED_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r <= SPEED_MIN_RST;
    end else if (adv) begin
      speed_r <= speed_nxt;
    end
  end

endmodule

/* hw/rtl/three_key_speed_panel.sv */
// ----------------------------------------------------------------------------
// three_key_speed_panel: key panel controller for a speed setpoint
// Each input transaction is one scan tick with the levels of the decrement,
// increment and start keys. Each tick yields exactly one result transaction:
// setpoint, run status, mode command, and beep, flash and activity flags.
// Channels use valid/stall; configuration is a write-only register port
// (0 scan period, 1 lower setpoint limit, 2 upper setpoint limit); the user
// must see that it is written only while idle, as the block does not enforce it.
// The input register is loaded at the accepting edge; once the result
// register is free, the key timers, setpoint clamps and activity countdown
// evaluate in one pass into the result register.
// Throughput is one tick per cycle while the receiver does not stall.
// When the receiver stalls, the result register holds and the input register
// fills; the input side stalls only once both are occupied.
// Synchronous reset clears both stages, all key timers and the run status,
// loads the setpoint with 100 and the registers with their default values.
// ----------------------------------------------------------------------------
module three_key_speed_panel (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_dec_key_down,
  input  logic                            in_inc_key_down,
  input  logic                            in_start_key_down,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [tksp_pkg::SPEED_W-1:0]    out_speed_setpoint,
  output logic                            out_running,
  output logic [1:0]                      out_mode_command,
  output logic                            out_settings_changed,
  output logic                            out_short_beep,
  output logic                            out_flash_request,
  output logic                            out_recently_operated,
  input  logic                            cfg_wr_en,
  input  logic [tksp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tksp_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import tksp_pkg::*;

  logic [TICK_W-1:0]  tick_r;
  logic [SPEED_W-1:0] min_r;
  logic [SPEED_W-1:0] max_r;

  logic               s1_valid_r;
  logic               dec_r, inc_r, start_r;
  logic               out_ready;
  logic               adv;
  logic               in_take;

  logic               dec_step, inc_step;
  start_evt_t         start_evt;
  logic [SPEED_W-1:0] speed_nxt;
  logic [ACT_W-1:0]   act_r, act_nxt;

  assign out_ready = !out_valid || !out_stall;
  assign adv       = s1_valid_r && out_ready;
  assign in_stall  = s1_valid_r && !out_ready;
  assign in_take   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r <= TICK_MS_RST;
      min_r  <= SPEED_MIN_RST;
      max_r  <= SPEED_MAX_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_TICK_MS:   tick_r <= cfg_wdata[TICK_W-1:0];
        CFG_SPEED_MIN: min_r  <= cfg_wdata[SPEED_W-1:0];
        CFG_SPEED_MAX: max_r  <= cfg_wdata[SPEED_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      dec_r   <= in_dec_key_down;
      inc_r   <= in_inc_key_down;
      start_r <= in_start_key_down;
    end
  end

  tksp_speed_key u_dec_key (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .pressed  (dec_r),
    .tick_ms  (tick_r),
    .step     (dec_step)
  );

  tksp_speed_key u_inc_key (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .pressed  (inc_r),
    .tick_ms  (tick_r),
    .step     (inc_step)
  );

  tksp_start_key u_start_key (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .pressed  (start_r),
    .tick_ms  (tick_r),
    .evt      (start_evt)
  );

  tksp_setpoint u_setpoint (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .dec_step  (dec_step),
    .inc_step  (inc_step),
    .lo_limit  (min_r),
    .hi_limit  (max_r),
    .speed_nxt (speed_nxt)
  );

  always_comb begin
    if (act_r > {{(ACT_W - TICK_W){1'b0}}, tick_r}) begin
      act_nxt = act_r - {{(ACT_W - TICK_W){1'b0}}, tick_r};
    end else begin
      act_nxt = '0;
    end
    if (dec_step || inc_step) begin
      act_nxt = ACTIVITY_MS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= '0;
    end else if (adv) begin
      act_r <= act_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_speed_setpoint    <= speed_nxt;
      out_running           <= start_evt.running;
      out_mode_command      <= start_evt.mode;
      out_settings_changed  <= dec_step | inc_step | start_evt.click;
      out_short_beep        <= dec_step | inc_step | start_evt.click;
      out_flash_request     <= start_evt.flash;
      out_recently_operated <= (act_nxt != '0);
    end
  end

endmodule
